### src/bhrg_pkg.sv
// Package with the codes, constants and state type of the bounded hash random generator.
`timescale 1ns / 1ps

package bhrg_pkg;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_RAW     = 2'd1;
	localparam logic [1:0] OP_BOUNDED = 2'd2;

	localparam logic [31:0] WEYL_STEP = 32'h9e37_79b9;
	localparam logic [31:0] MIX_MUL_A = 32'h7feb_352d;
	localparam logic [31:0] MIX_MUL_B = 32'h846c_a68b;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_CUT,
		ST_DRAW,
		ST_MUL_A,
		ST_MUL_B,
		ST_CHECK,
		ST_DIV_MOD,
		ST_FINISH
	} state_t;

endpackage

### src/bounded_hash_random_generator_top.sv
// Top level of the bounded hash random generator with its sequencer and shared units.
`timescale 1ns / 1ps

// Each request on the input channel (operation, operand) yields exactly one
// value on the output channel, both under valid and ready.
// A seed load writes the Weyl counter and presents zero once the request is
// taken. A raw draw advances the counter in ST_DRAW, hashes it with one shared
// multiplier in ST_MUL_A and ST_MUL_B and presents the hash through ST_CHECK
// and ST_FINISH. A bounded draw first finds the rejection cutoff with a
// restoring divider that retires one bit per cycle, then takes draws until
// one reaches the cutoff, and reduces it modulo the bound with the same divider.
// A bound of zero and the unused operation code present zero as well and
// leave the counter alone.
// One request is worked on at a time and in_ready is high only while the
// sequencer is idle.
// A finished value sits in an output register, so the next request is taken
// while it waits; a later result waits in its last state until the receiver
// has taken the earlier one.
// Reset clears the counter to zero and empties the output register.
module bounded_hash_random_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value
);
	import bhrg_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic [1:0]  op_q;
	logic [31:0] ctr_q;
	logic [31:0] bound_q;
	logic [31:0] cutoff_q;
	logic [31:0] work_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] value_q;

	logic        in_fire;
	logic        out_free;
	logic [32:0] shifted;
	logic        div_ge;
	logic [31:0] rem_next;
	logic [31:0] ctr_next;
	logic [31:0] mul_b;
	logic [31:0] product;
	logic        div_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	assign shifted  = {rem_q, dvd_q[31]};
	assign div_ge   = (shifted >= {1'b0, bound_q});
	assign rem_next = div_ge ? 32'(shifted - {1'b0, bound_q}) : shifted[31:0];
	assign div_last = (cnt_q == 5'd31);

	assign ctr_next = ctr_q + WEYL_STEP;
	assign mul_b    = (state_q == ST_MUL_A) ? MIX_MUL_A : MIX_MUL_B;
	assign product  = 32'(work_q * mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (operation == OP_RAW) begin
						state_d = ST_DRAW;
					end else if (operation == OP_BOUNDED && operand != 32'd0) begin
						state_d = ST_DIV_CUT;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_DIV_CUT: begin
				if (div_last) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW:  state_d = ST_MUL_A;
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_CHECK;
			ST_CHECK: begin
				if (op_q != OP_BOUNDED) begin
					state_d = ST_FINISH;
				end else if (work_q < cutoff_q) begin
					state_d = ST_DRAW;
				end else begin
					state_d = ST_DIV_MOD;
				end
			end
			ST_DIV_MOD: begin
				if (div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire && operation == OP_LOAD) begin
				ctr_q <= operand;
			end else if (state_q == ST_DRAW) begin
				ctr_q <= ctr_next;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q    <= operation;
				bound_q <= operand;
				work_q  <= 32'd0;
				rem_q   <= 32'd0;
				dvd_q   <= 32'd0 - operand;
				cnt_q   <= 5'd0;
			end
			ST_DIV_CUT, ST_DIV_MOD: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[30:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (div_last) begin
					if (state_q == ST_DIV_CUT) begin
						cutoff_q <= rem_next;
					end else begin
						work_q <= rem_next;
					end
				end
			end
			ST_DRAW: begin
				work_q <= ctr_next ^ (ctr_next >> 16);
			end
			ST_MUL_A: begin
				work_q <= product ^ (product >> 15);
			end
			ST_MUL_B: begin
				work_q <= product ^ (product >> 16);
			end
			ST_CHECK: begin
				rem_q <= 32'd0;
				dvd_q <= work_q;
				cnt_q <= 5'd0;
			end
			ST_FINISH: begin
				if (out_free) begin
					value_q <= work_q;
				end
			end
			default: begin
			end
		endcase
	end

	// The remainder never reaches the bound while the divider runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_CUT || state_q == ST_DIV_MOD) |-> (rem_q < bound_q))
		else $error("divider remainder reached the bound");

	// Once a bounded draw is hashing, the cutoff is below the bound.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_A && op_q == OP_BOUNDED) |-> (cutoff_q < bound_q))
		else $error("rejection cutoff not below the bound");

	// The counter moves only on a draw or a seed load.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DRAW && !in_fire) |=> $stable(ctr_q))
		else $error("Weyl counter changed outside a draw or load");

	// A finished result waits while the previous one is still held.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && !out_ready) |=> (state_q == ST_FINISH))
		else $error("result left the sequencer while the output was stalled");

	// A result appears only after the sequencer's last state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("output became valid without a finished request");

endmodule
